// File: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// Tick task scheduler package
// Shared types, codes and constants for the task table, its slot memory,
// the slot update unit and the sequencer.
// ----------------------------------------------------------------------------
package tts_pkg;

    // Default number of task slots.
    localparam int DEF_MAX_TASKS = 16;

    // A dispatch hands out at most this many tasks.
    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

    // Field widths of the request and result items.
    localparam int MODE_W   = 2;
    localparam int TICKS_W  = 16;
    localparam int HANDLE_W = 16;
    localparam int SIDX_W   = 5;
    localparam int STAT_W   = 2;
    localparam int RIDX_W   = 5;
    localparam int RUNS_W   = 8;

    // Request codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_DEL  = 2'd2,
        MODE_DISP = 2'd3
    } t_mode;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_NONE  = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } t_state;

    // One slot of the task table as held in the slot memory.
    typedef struct packed {
        logic [TICKS_W-1:0]  delay;
        logic [TICKS_W-1:0]  period;
        logic [RUNS_W-1:0]   pending;
        logic [HANDLE_W-1:0] handle;
    } t_slot;

    // Decision of the slot update unit for the slot under work.
    typedef struct packed {
        logic  hit;        // slot taken (add) or dispatched (dispatch)
        logic  wr_en;      // write the updated slot back
        logic  clr_valid;  // one-shot task freed after its run
        t_slot word;       // updated slot contents
    } t_unit_res;

    // Result item without the final-result flag.
    typedef struct packed {
        t_status             status;
        logic [RIDX_W-1:0]   index;
        logic [HANDLE_W-1:0] handle;
    } t_result;

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic    valid;
        t_result result;
        logic    last;
    } t_push;

endpackage

// File: rtl/tts_slot_mem.sv
// ----------------------------------------------------------------------------
// Slot memory
// One entry per task slot, one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tts_slot_mem
    import tts_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_TASKS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_slot         i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_slot         o_rd_data
);

    t_slot r_mem [DEPTH];
    t_slot r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/tts_slot_unit.sv
// ----------------------------------------------------------------------------
// Slot update unit
// Works out the new contents of one slot for a tick, an add or a dispatch.
// The sequencer runs the slots of the table through this one unit in turn.
// ----------------------------------------------------------------------------
module tts_slot_unit
    import tts_pkg::*;
(
    input  t_mode     i_mode,
    input  logic      i_occupied,
    input  t_slot     i_slot,
    input  t_slot     i_new,
    output t_unit_res o_res
);

    always_comb begin
        o_res      = '0;
        o_res.word = i_slot;
        case (i_mode)
            MODE_TICK: begin
                // Count down, or schedule a run once the delay has expired.
                if (i_occupied) begin
                    o_res.wr_en = 1'b1;
                    if (i_slot.delay == '0) begin
                        if (i_slot.pending != '1) begin
                            o_res.word.pending = i_slot.pending + 1'b1;
                        end
                        if (i_slot.period != '0) begin
                            o_res.word.delay = i_slot.period - 1'b1;
                        end
                    end else begin
                        o_res.word.delay = i_slot.delay - 1'b1;
                    end
                end
            end
            MODE_ADD: begin
                // A free slot takes the new task.
                if (!i_occupied) begin
                    o_res.hit   = 1'b1;
                    o_res.wr_en = 1'b1;
                    o_res.word  = i_new;
                end
            end
            MODE_DISP: begin
                // Hand out one pending run; a one-shot task is then freed.
                if (i_occupied && (i_slot.pending != '0)) begin
                    o_res.hit          = 1'b1;
                    o_res.wr_en        = 1'b1;
                    o_res.word.pending = i_slot.pending - 1'b1;
                    o_res.clr_valid    = (i_slot.period == '0);
                end
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

// File: rtl/tts_sequencer.sv
// ----------------------------------------------------------------------------
// Task table sequencer
// Holds the slot occupancy bits and walks the slot memory, one slot a cycle
// while not stalled, through the slot update unit, collecting request results.
// ----------------------------------------------------------------------------
module tts_sequencer
    import tts_pkg::*;
#(
    parameter int MAX_TASKS = DEF_MAX_TASKS,
    parameter int IW        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [TICKS_W-1:0]  i_start_delay,
    input  logic [TICKS_W-1:0]  i_repeat_period,
    input  logic [HANDLE_W-1:0] i_task_handle,
    input  logic [SIDX_W-1:0]   i_slot_index,
    input  logic                i_out_free,
    output t_push               o_push,
    output logic                o_rd_en,
    output logic [IW-1:0]       o_rd_addr,
    input  t_slot               i_rd_data,
    output logic                o_wr_en,
    output logic [IW-1:0]       o_wr_addr,
    output t_slot               o_wr_data
);

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0]     END_IDX  = CW'(MAX_TASKS);
    localparam logic [RIDX_W-1:0] FULL_IDX = RIDX_W'(MAX_TASKS % 32);
    localparam logic [CNT_W-1:0]  CNT_LIM  = CNT_W'(RESULT_LIMIT);

    t_state               r_state, n_state;
    logic [MAX_TASKS-1:0] r_valid, n_valid;
    logic [CW-1:0]        r_rd_idx, n_rd_idx;
    logic                 r_ex_valid, n_ex_valid;
    logic [IW-1:0]        r_ex_idx, n_ex_idx;
    logic                 r_hold_valid, n_hold_valid;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    t_result              r_hold, n_hold;
    t_mode                r_mode, n_mode;
    t_slot                r_new, n_new;

    t_unit_res            w_unit;
    logic                 w_stall;
    logic                 w_ex_go;
    logic [IW-1:0]        w_del_idx;
    logic [CNT_W-1:0]     w_cnt_inc;

    // Shared slot update unit.
    tts_slot_unit u_unit (
        .i_mode     (r_mode),
        .i_occupied (r_valid[r_ex_idx]),
        .i_slot     (i_rd_data),
        .i_new      (r_new),
        .o_res      (w_unit)
    );

    assign w_del_idx = IW'(i_slot_index);
    assign w_cnt_inc = r_cnt + 1'b1;

    // A dispatch hit must push the held result first, which needs a free
    // output register.
    assign w_stall = r_ex_valid && (r_mode == MODE_DISP) && w_unit.hit
                     && r_hold_valid && !i_out_free;
    assign w_ex_go = r_ex_valid && !w_stall;

    // Next state and outputs.
    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_rd_idx     = r_rd_idx;
        n_ex_valid   = r_ex_valid;
        n_ex_idx     = r_ex_idx;
        n_hold_valid = r_hold_valid;
        n_cnt        = r_cnt;
        n_hold       = r_hold;
        n_mode       = r_mode;
        n_new        = r_new;
        o_in_ready   = 1'b0;
        o_push       = '0;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_rd_idx[IW-1:0];
        o_wr_en      = 1'b0;
        o_wr_addr    = r_ex_idx;
        o_wr_data    = w_unit.word;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mode         = t_mode'(i_mode);
                    n_new.delay    = i_start_delay;
                    n_new.period   = i_repeat_period;
                    n_new.pending  = '0;
                    n_new.handle   = i_task_handle;
                    n_rd_idx       = '0;
                    n_ex_valid     = 1'b0;
                    n_cnt          = '0;
                    n_hold_valid   = 1'b0;
                    if (t_mode'(i_mode) == MODE_DEL) begin
                        // A delete only touches the occupancy bit.
                        n_hold.index  = i_slot_index;
                        n_hold.handle = '0;
                        if (32'(i_slot_index) >= MAX_TASKS) begin
                            n_hold.status = STAT_RANGE;
                        end else begin
                            n_hold.status      = STAT_OK;
                            n_valid[w_del_idx] = 1'b0;
                        end
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end

            S_WALK: begin
                // Issue the read of the next slot.
                if (!w_stall) begin
                    if (r_rd_idx != END_IDX) begin
                        o_rd_en    = 1'b1;
                        n_ex_valid = 1'b1;
                        n_ex_idx   = r_rd_idx[IW-1:0];
                        n_rd_idx   = r_rd_idx + 1'b1;
                    end else begin
                        n_ex_valid = 1'b0;
                    end
                end

                // Update the slot whose data has come back.
                if (w_ex_go) begin
                    o_wr_en = w_unit.wr_en;
                    if (w_unit.clr_valid) begin
                        n_valid[r_ex_idx] = 1'b0;
                    end
                    if (w_unit.hit && (r_mode == MODE_ADD)) begin
                        n_valid[r_ex_idx] = 1'b1;
                        n_hold.status     = STAT_OK;
                        n_hold.index      = RIDX_W'(r_ex_idx);
                        n_hold.handle     = '0;
                        n_hold_valid      = 1'b1;
                        n_state           = S_FINISH;
                    end
                    if (w_unit.hit && (r_mode == MODE_DISP)) begin
                        if (r_hold_valid) begin
                            o_push.valid  = 1'b1;
                            o_push.result = r_hold;
                            o_push.last   = 1'b0;
                        end
                        n_hold.status = STAT_OK;
                        n_hold.index  = RIDX_W'(r_ex_idx);
                        n_hold.handle = i_rd_data.handle;
                        n_hold_valid  = 1'b1;
                        n_cnt         = w_cnt_inc;
                        if (w_cnt_inc == CNT_LIM) begin
                            n_state = S_FINISH;
                        end
                    end
                end

                // Every slot seen: settle the final result.
                if (!r_ex_valid && (r_rd_idx == END_IDX)) begin
                    n_state = S_FINISH;
                    case (r_mode)
                        MODE_TICK: begin
                            n_hold.status = STAT_OK;
                            n_hold.index  = '0;
                            n_hold.handle = '0;
                        end
                        MODE_ADD: begin
                            n_hold.status = STAT_FULL;
                            n_hold.index  = FULL_IDX;
                            n_hold.handle = '0;
                        end
                        MODE_DISP: begin
                            if (!r_hold_valid) begin
                                n_hold.status = STAT_NONE;
                                n_hold.index  = '0;
                                n_hold.handle = '0;
                            end
                        end
                        default: begin
                            n_hold = r_hold;
                        end
                    endcase
                end
            end

            S_FINISH: begin
                // Hand over the final result of the request.
                if (i_out_free) begin
                    o_push.valid  = 1'b1;
                    o_push.result = r_hold;
                    o_push.last   = 1'b1;
                    n_hold_valid  = 1'b0;
                    n_state       = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_rd_idx     <= '0;
            r_ex_valid   <= 1'b0;
            r_hold_valid <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_rd_idx     <= n_rd_idx;
            r_ex_valid   <= n_ex_valid;
            r_hold_valid <= n_hold_valid;
            r_cnt        <= n_cnt;
        end
    end

    // Request fields and held result.
    always_ff @(posedge i_clk) begin
        r_ex_idx <= n_ex_idx;
        r_hold   <= n_hold;
        r_mode   <= n_mode;
        r_new    <= n_new;
    end

endmodule

// File: rtl/tick_task_scheduler_table.sv
// ----------------------------------------------------------------------------
// Tick task scheduler table
// Task table with tick, add, delete and dispatch requests and an output
// register for the results.
// ----------------------------------------------------------------------------
// A tick, an add or a dispatch walks the slot table one slot per cycle,
// unless stalled, through a single slot update unit fed by the one read
// port of the slot memory, so a tick or a full dispatch visits every slot
// and an add stops at the first free slot or walks the whole table when it
// is full. A dispatch gives one result per ready task, at most sixteen, and
// pauses while the output register is still held by the consumer. A new
// request is taken as soon as the last result of the previous one sits in
// the output register. Occupancy bits are cleared by reset, so the table is
// usable in the first cycle after reset.
module tick_task_scheduler_table
    import tts_pkg::*;
#(
    parameter int MAX_TASKS = DEF_MAX_TASKS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [TICKS_W-1:0]  i_start_delay,
    input  logic [TICKS_W-1:0]  i_repeat_period,
    input  logic [HANDLE_W-1:0] i_task_handle,
    input  logic [SIDX_W-1:0]   i_slot_index,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STAT_W-1:0]   o_status,
    output logic [RIDX_W-1:0]   o_result_index,
    output logic [HANDLE_W-1:0] o_run_handle,
    output logic                o_last_result
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    t_push         w_push;
    logic          w_out_free;
    logic          w_rd_en;
    logic [IW-1:0] w_rd_addr;
    t_slot         w_rd_data;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_addr;
    t_slot         w_wr_data;

    logic          r_out_valid;
    t_result       r_out;
    logic          r_out_last;

    assign w_out_free = !r_out_valid || i_out_ready;

    // Sequencer with the shared slot update unit.
    tts_sequencer #(
        .MAX_TASKS (MAX_TASKS),
        .IW        (IW)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_start_delay   (i_start_delay),
        .i_repeat_period (i_repeat_period),
        .i_task_handle   (i_task_handle),
        .i_slot_index    (i_slot_index),
        .i_out_free      (w_out_free),
        .o_push          (w_push),
        .o_rd_en         (w_rd_en),
        .o_rd_addr       (w_rd_addr),
        .i_rd_data       (w_rd_data),
        .o_wr_en         (w_wr_en),
        .o_wr_addr       (w_wr_addr),
        .o_wr_data       (w_wr_data)
    );

    // Slot contents.
    tts_slot_mem #(
        .DEPTH (MAX_TASKS),
        .AW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_push.valid) begin
            r_out      <= w_push.result;
            r_out_last <= w_push.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_result_index = r_out.index;
    assign o_run_handle   = r_out.handle;
    assign o_last_result  = r_out_last;

endmodule
